[rtl/core/vclg_pkg.sv]
package vclg_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_CATEGORIES_DEF = 4;
	localparam int ACC_WIDTH_DEF      = 48;

	// Fixed field widths
	localparam int OUTCOME_W   = 2;
	localparam int AVAIL_W     = 4;
	localparam int MEMB_W      = 17;
	localparam int COUNT_W     = 3;
	localparam int WEIGHT_W    = 24;
	localparam int GRAD_W      = 48;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	// Lane index covers up to three non-baseline categories
	localparam int LANE_W = 2;

	// Arithmetic widths
	localparam int DENOM_W   = 26;
	localparam int QUO_W     = 17;
	localparam int QCNT_W    = 5;
	localparam int DERIV_W   = 18;
	localparam int PROD_W    = 36;
	localparam int CONTRIB_W = PROD_W - 16;

	localparam logic [QUO_W-1:0]    ONE_Q16       = QUO_W'(65536);
	localparam logic [COUNT_W-1:0]  COUNT_RESET   = COUNT_W'(4);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = WEIGHT_W'(65536);

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CATEGORY_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_BASE    = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DENOM,
		S_SCAN,
		S_DIV,
		S_MUL,
		S_ACC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              add;
		logic              clear;
		logic [LANE_W-1:0] lane;
	} acc_ctrl_t;

endpackage

[rtl/core/vclg_div.sv]
module vclg_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [vclg_pkg::WEIGHT_W-1:0]  dividend,
	input  logic [vclg_pkg::DENOM_W-1:0]   divisor,
	output logic                           done,
	output logic [vclg_pkg::QUO_W-1:0]     quotient
);
	import vclg_pkg::*;

	// Restoring divider of (dividend << 16) by divisor, one quotient bit a cycle.
	// The quotient never exceeds one in Q1.16 since dividend <= divisor.
	logic [DENOM_W-1:0] rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               done_q;

	logic [DENOM_W:0]   trial;
	logic               ge;
	logic [DENOM_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[QUO_W-1]};
		ge       = trial >= {1'b0, divisor};
		rem_next = ge ? DENOM_W'(trial - {1'b0, divisor}) : DENOM_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= QCNT_W'(QUO_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - QCNT_W'(1);
			done_q <= (cnt_q == QCNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(DENOM_W-WEIGHT_W+1){1'b0}}, dividend[WEIGHT_W-1:1]};
			quo_q <= {dividend[0], {(QUO_W-1){1'b0}}};
		end else if (cnt_q != '0) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/vclg_acc.sv]
module vclg_acc #(
	parameter int ACC_WIDTH = vclg_pkg::ACC_WIDTH_DEF,
	parameter int NUM_SUMS  = vclg_pkg::MAX_CATEGORIES_DEF - 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vclg_pkg::acc_ctrl_t                  ctrl,
	input  logic signed [vclg_pkg::CONTRIB_W-1:0] contrib,
	output logic signed [ACC_WIDTH-1:0]          neg [NUM_SUMS]
);
	import vclg_pkg::*;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	logic signed [ACC_WIDTH-1:0] sum_q [NUM_SUMS];
	logic [ACC_WIDTH-1:0]        sel;
	logic [ACC_WIDTH:0]          total;
	logic [ACC_WIDTH-1:0]        sat;

	// One shared saturating adder; the selected lane feeds it
	always_comb begin
		sel = '0;
		for (int i = 0; i < NUM_SUMS; i++) begin
			if (ctrl.lane == LANE_W'(i)) sel = sel | sum_q[i];
		end
		total = {sel[ACC_WIDTH-1], sel}
		      + {{(ACC_WIDTH+1-CONTRIB_W){contrib[CONTRIB_W-1]}}, contrib};
		if (total[ACC_WIDTH] != total[ACC_WIDTH-1]) begin
			sat = total[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end else begin
			sat = total[ACC_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUMS; i++) sum_q[i] <= '0;
		end else if (ctrl.clear) begin
			for (int i = 0; i < NUM_SUMS; i++) sum_q[i] <= '0;
		end else if (ctrl.add) begin
			for (int i = 0; i < NUM_SUMS; i++) begin
				if (ctrl.lane == LANE_W'(i)) sum_q[i] <= sat;
			end
		end
	end

	// Negate for the result; the most negative sum maps to the largest positive
	always_comb begin
		for (int i = 0; i < NUM_SUMS; i++) begin
			neg[i] = (sum_q[i] == ACC_MIN) ? ACC_MAX : -sum_q[i];
		end
	end

endmodule

[rtl/core/varying_choice_logit_gradient.sv]
// Weighted gradient engine for a varying-choice multinomial logit. Each sample
// transaction carries the observed outcome, an availability mask and a Q1.16
// membership weight; the configuration registers hold exp(coefficient) for
// categories one to three in Q8.16, the baseline category zero weighing one.
// For every available non-baseline category in range the block adds
// membership * ([outcome == l] - w_l / denom) to a saturating ACC_WIDTH-bit
// sum. A sample marked final_sample closes the run: one result transaction
// carries the negated sums (zero for categories beyond the count) and a
// sticky flag that is set when any sample of the run had a zero denominator,
// and the sums and flag return to zero. A sample passes through a denominator
// state, then a scan state for each category in range and one more to end the
// scan; for each of those that is available the divider forms the quotient,
// then the product is formed and then accumulated. A closing state follows,
// then the idle state in which the next sample is taken; a zero denominator
// skips the scan. The single radix-2 divider yields one quotient bit a cycle
// and is shared across categories; sample_ready is low throughout. The result
// sits in an output register, so the next sample is taken while it waits; a
// further final sample holds until the earlier result has been taken.
// Configuration writes take effect at once and must be made between samples.
module varying_choice_logit_gradient #(
	parameter int MAX_CATEGORIES = vclg_pkg::MAX_CATEGORIES_DEF,
	parameter int ACC_WIDTH      = vclg_pkg::ACC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_we,
	input  logic [vclg_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [vclg_pkg::CFG_DATA_W-1:0]        cfg_data,

	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic [vclg_pkg::OUTCOME_W-1:0]         outcome,
	input  logic [vclg_pkg::AVAIL_W-1:0]           avail_mask,
	input  logic [vclg_pkg::MEMB_W-1:0]            membership,
	input  logic                                   final_sample,

	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [vclg_pkg::GRAD_W-1:0]     grad_one,
	output logic signed [vclg_pkg::GRAD_W-1:0]     grad_two,
	output logic signed [vclg_pkg::GRAD_W-1:0]     grad_three,
	output logic                                   denom_fault
);
	import vclg_pkg::*;

	localparam int NUM_SUMS = MAX_CATEGORIES - 1;
	localparam int NUM_OUT  = 3;

	// Configuration registers
	logic [COUNT_W-1:0]  count_q;
	logic [WEIGHT_W-1:0] weight_q [NUM_SUMS];

	// Latched sample
	logic [OUTCOME_W-1:0] outcome_q;
	logic [AVAIL_W-1:0]   avail_q;
	logic [MEMB_W-1:0]    memb_q;
	logic                 last_q;

	// Sequencer and datapath
	state_t                     state_q, state_d;
	logic [LANE_W-1:0]          lane_q;
	logic [DENOM_W-1:0]         denom_q;
	logic                       fault_q;
	logic signed [PROD_W-1:0]   prod_q;

	logic [GRAD_W-1:0]          grad_one_q, grad_two_q, grad_three_q;
	logic                       result_valid_q;
	logic                       denom_fault_q;

	logic [COUNT_W-1:0]         eff_cnt;
	logic [DENOM_W-1:0]         denom_d;
	logic [WEIGHT_W-1:0]        w_sel;
	logic                       av_sel;
	logic                       lane_in_range;
	logic                       slot_free;
	logic                       accept;
	logic                       div_start;
	logic                       div_done;
	logic [QUO_W-1:0]           quotient;
	logic signed [DERIV_W-1:0]  deriv;
	logic signed [PROD_W-1:0]   prod_d;
	logic                       load_result;
	acc_ctrl_t                  acc_ctrl;
	logic signed [ACC_WIDTH-1:0] neg [NUM_SUMS];
	logic [GRAD_W-1:0]          grad_ext [NUM_OUT];
	logic [NUM_OUT-1:0]         out_used;

	assign accept    = sample_valid && sample_ready;
	assign slot_free = !result_valid_q || result_ready;

	// Clamp the category count into the supported range
	always_comb begin
		eff_cnt = count_q;
		if (eff_cnt < COUNT_W'(2)) eff_cnt = COUNT_W'(2);
		if (eff_cnt > COUNT_W'(MAX_CATEGORIES)) eff_cnt = COUNT_W'(MAX_CATEGORIES);
	end

	// Denominator from the incoming sample: baseline bit plus available weights
	always_comb begin
		denom_d = avail_mask[0] ? DENOM_W'(ONE_Q16) : '0;
		for (int i = 0; i < NUM_SUMS; i++) begin
			if (avail_mask[i+1] && (COUNT_W'(i + 1) < eff_cnt)) begin
				denom_d = denom_d + DENOM_W'(weight_q[i]);
			end
		end
	end

	// Operands of the current lane
	always_comb begin
		w_sel  = '0;
		av_sel = 1'b0;
		for (int i = 0; i < NUM_SUMS; i++) begin
			if (lane_q == LANE_W'(i)) begin
				w_sel  = weight_q[i];
				av_sel = avail_q[i+1];
			end
		end
		lane_in_range = (COUNT_W'(lane_q) + COUNT_W'(1)) < eff_cnt;
	end

	// Indicator minus quotient, then weighted by membership
	always_comb begin
		deriv = -signed'({1'b0, quotient});
		if (COUNT_W'(outcome_q) == COUNT_W'(lane_q) + COUNT_W'(1)) begin
			deriv = deriv + signed'(DERIV_W'(ONE_Q16));
		end
		prod_d = PROD_W'(signed'({1'b0, memb_q}) * deriv);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			for (int i = 0; i < NUM_SUMS; i++) weight_q[i] <= WEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CATEGORY_COUNT) count_q <= cfg_data[COUNT_W-1:0];
			for (int i = 0; i < NUM_SUMS; i++) begin
				if (cfg_index == REG_WEIGHT_BASE + CFG_INDEX_W'(i)) begin
					weight_q[i] <= cfg_data[WEIGHT_W-1:0];
				end
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d        = state_q;
		sample_ready   = 1'b0;
		div_start      = 1'b0;
		load_result    = 1'b0;
		acc_ctrl.add   = 1'b0;
		acc_ctrl.clear = 1'b0;
		acc_ctrl.lane  = lane_q;
		case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) state_d = S_DENOM;
			end
			S_DENOM: begin
				// A zero denominator contributes nothing
				state_d = (denom_q == '0) ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				if (!lane_in_range) begin
					state_d = S_DONE;
				end else if (av_sel) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				acc_ctrl.add = 1'b1;
				state_d      = S_SCAN;
			end
			S_DONE: begin
				if (!last_q) begin
					state_d = S_IDLE;
				end else if (slot_free) begin
					load_result    = 1'b1;
					acc_ctrl.clear = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Capture the sample and denominator on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_q <= outcome;
			avail_q   <= avail_mask;
			memb_q    <= membership;
			last_q    <= final_sample;
			denom_q   <= denom_d;
		end
		if (state_q == S_MUL) prod_q <= prod_d;
	end

	// Lane walk: restart on a new sample, advance past each lane in range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else if (accept) begin
			lane_q <= '0;
		end else if ((state_q == S_ACC) || (state_q == S_SCAN && lane_in_range && !av_sel)) begin
			lane_q <= lane_q + LANE_W'(1);
		end
	end

	// Sticky fault for the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= 1'b0;
		end else if (load_result) begin
			fault_q <= 1'b0;
		end else if (state_q == S_DENOM && denom_q == '0) begin
			fault_q <= 1'b1;
		end
	end

	vclg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (w_sel),
		.divisor  (denom_q),
		.done     (div_done),
		.quotient (quotient)
	);

	vclg_acc #(
		.ACC_WIDTH (ACC_WIDTH),
		.NUM_SUMS  (NUM_SUMS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.contrib (prod_q[PROD_W-1:16]),
		.neg     (neg)
	);

	// Fit each negated sum to the result width; drop lanes beyond the count
	for (genvar j = 0; j < NUM_OUT; j++) begin : g_out
		if (j < NUM_SUMS) begin : g_lane
			if (ACC_WIDTH >= GRAD_W) begin : g_trunc
				assign grad_ext[j] = neg[j][GRAD_W-1:0];
			end else begin : g_sext
				assign grad_ext[j] = {{(GRAD_W-ACC_WIDTH){neg[j][ACC_WIDTH-1]}}, neg[j]};
			end
		end else begin : g_none
			assign grad_ext[j] = '0;
		end
		assign out_used[j] = COUNT_W'(j + 1) < eff_cnt;
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			grad_one_q    <= out_used[0] ? grad_ext[0] : '0;
			grad_two_q    <= out_used[1] ? grad_ext[1] : '0;
			grad_three_q  <= out_used[2] ? grad_ext[2] : '0;
			denom_fault_q <= fault_q;
		end
	end

	assign result_valid = result_valid_q;
	assign grad_one     = grad_one_q;
	assign grad_two     = grad_two_q;
	assign grad_three   = grad_three_q;
	assign denom_fault  = denom_fault_q;

endmodule
